// ----- hdl/hed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hed_pkg;

  // default offset limit for the closing ';' of an entity
  localparam int SEMI_LIMIT_DFLT = 10;

  // where an emitted byte comes from
  typedef enum logic [1:0] {
    SRC_FRONT = 2'd0,
    SRC_NAMED = 2'd1,
    SRC_NUM   = 2'd2
  } hed_src_t;

  typedef struct packed {
    logic     accept;
    logic     scan_start;
    logic     scan_step;
    logic     emit;
    hed_src_t src;
  } hed_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic single;
    logic multi;
    logic full;
    logic front_amp;
    logic at_end;
    logic named_hit;
    logic num_cand;
    logic scan_done;
    logic scan_ok;
    logic out_free;
  } hed_sts_t;

endpackage

`default_nettype wire

// ----- hdl/hed_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface hed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source(output valid, out_byte, out_last, input ready);
  modport sink(input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/hed_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hed_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hed_pkg::hed_sts_t sts,
  output hed_pkg::hed_cmd_t      cmd
);
  import hed_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.emit       = 1'b0;
    cmd.src        = SRC_FRONT;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.front_amp && !sts.at_end && !sts.full) begin
          // entity still open, wait for more bytes
          state_nxt = ST_IDLE;
        end else if (sts.front_amp && sts.multi && sts.named_hit) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_NAMED;
          end
        end else if (sts.front_amp && sts.multi && sts.num_cand) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_FRONT;
          if (sts.single) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = sts.scan_ok ? SRC_NUM : SRC_FRONT;
          state_nxt = ST_DRAIN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/hed_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hed_dp #(
  parameter int SEMI_LIMIT = hed_pkg::SEMI_LIMIT_DFLT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hed_pkg::hed_cmd_t cmd,
  output hed_pkg::hed_sts_t      sts,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_byte,
  output logic                   out_last
);
  import hed_pkg::*;

  localparam int WIN_DEPTH = (SEMI_LIMIT + 1 > 6) ? SEMI_LIMIT + 1 : 6;
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int IDX_W     = $clog2(WIN_DEPTH);

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
    return v;
  endfunction

  logic [7:0]       win_r   [WIN_DEPTH];
  logic [7:0]       win_nxt [WIN_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             at_end_r;
  logic [CNT_W-1:0] k_r;
  logic [6:0]       acc_r;
  logic             big_r;
  logic             hex_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  // named entity match on fixed taps
  logic hit_lt, hit_gt, hit_amp, hit_quot, hit_apos;
  logic [7:0]       named_ch;
  logic [CNT_W-1:0] named_len;
  logic             hex_cand;

  assign hit_lt   = (cnt_r >= CNT_W'(4)) && win_r[1] == CH_L && win_r[2] == CH_T
                    && win_r[3] == CH_SEMI;
  assign hit_gt   = (cnt_r >= CNT_W'(4)) && win_r[1] == CH_G && win_r[2] == CH_T
                    && win_r[3] == CH_SEMI;
  assign hit_amp  = (cnt_r >= CNT_W'(5)) && win_r[1] == CH_A && win_r[2] == CH_M
                    && win_r[3] == CH_P && win_r[4] == CH_SEMI;
  assign hit_quot = (cnt_r >= CNT_W'(6)) && win_r[1] == CH_Q && win_r[2] == CH_U
                    && win_r[3] == CH_O && win_r[4] == CH_T && win_r[5] == CH_SEMI;
  assign hit_apos = (cnt_r >= CNT_W'(6)) && win_r[1] == CH_A && win_r[2] == CH_P
                    && win_r[3] == CH_O && win_r[4] == CH_S && win_r[5] == CH_SEMI;

  always_comb begin
    named_ch  = CH_APOS;
    named_len = CNT_W'(6);
    if (hit_lt) begin
      named_ch  = CH_LT;
      named_len = CNT_W'(4);
    end else if (hit_gt) begin
      named_ch  = CH_GT;
      named_len = CNT_W'(4);
    end else if (hit_amp) begin
      named_ch  = CH_AMP;
      named_len = CNT_W'(5);
    end else if (hit_quot) begin
      named_ch  = CH_QUOTE;
      named_len = CNT_W'(6);
    end
  end

  assign hex_cand = (cnt_r >= CNT_W'(3)) && win_r[1] == CH_HASH
                    && (win_r[2] == CH_LX || win_r[2] == CH_UX);

  // numeric scan, one character a cycle
  logic        in_range;
  logic [7:0]  scan_byte;
  logic [4:0]  dig;
  logic        dig_ok;
  logic [10:0] acc_ext, acc_prod, acc_sum;
  logic        big_nxt;

  assign in_range  = k_r < cnt_r;
  assign scan_byte = in_range ? win_r[k_r[IDX_W-1:0]] : 8'h00;
  assign dig       = hex_val(scan_byte);
  assign dig_ok    = hex_r ? (dig < 5'd16) : (dig < 5'd10);
  assign acc_ext   = {4'b0, acc_r};
  assign acc_prod  = hex_r ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
  assign acc_sum   = acc_prod + {7'b0, dig[3:0]};
  assign big_nxt   = big_r || (acc_sum >= 11'd128);

  // bytes removed from the window front by an emit
  logic [CNT_W-1:0] drop_amt;

  always_comb begin
    case (cmd.src)
      SRC_FRONT: drop_amt = CNT_W'(1);
      SRC_NAMED: drop_amt = named_len;
      SRC_NUM:   drop_amt = k_r + CNT_W'(1);
      default:   drop_amt = CNT_W'(1);
    endcase
  end

  always_comb begin
    int sh;
    sh      = 0;
    cnt_nxt = cnt_r;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (cmd.accept) begin
      win_nxt[cnt_r[IDX_W-1:0]] = in_byte;
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.emit) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        sh = i + int'(drop_amt);
        if (sh < WIN_DEPTH) begin
          win_nxt[i] = win_r[IDX_W'(sh)];
        end
      end
      cnt_nxt = cnt_r - drop_amt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      at_end_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.accept) begin
        at_end_r <= in_last;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_r[i] <= win_nxt[i];
    end
    if (cmd.scan_start) begin
      k_r   <= hex_cand ? CNT_W'(3) : CNT_W'(2);
      acc_r <= '0;
      big_r <= 1'b0;
      hex_r <= hex_cand;
    end else if (cmd.scan_step) begin
      k_r   <= k_r + CNT_W'(1);
      acc_r <= acc_sum[6:0];
      big_r <= big_nxt;
    end
    if (cmd.emit) begin
      case (cmd.src)
        SRC_FRONT: out_byte_r <= win_r[0];
        SRC_NAMED: out_byte_r <= named_ch;
        SRC_NUM:   out_byte_r <= {1'b0, acc_r};
        default:   out_byte_r <= win_r[0];
      endcase
      out_last_r <= at_end_r && (cnt_r == drop_amt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.single    = (cnt_r == CNT_W'(1));
  assign sts.multi     = (cnt_r > CNT_W'(1));
  assign sts.full      = (cnt_r == CNT_W'(WIN_DEPTH));
  assign sts.front_amp = (win_r[0] == CH_AMP);
  assign sts.at_end    = at_end_r;
  assign sts.named_hit = hit_lt || hit_gt || hit_amp || hit_quot || hit_apos;
  assign sts.num_cand  = (win_r[1] == CH_HASH);
  assign sts.scan_done = !in_range || scan_byte == CH_SEMI || !dig_ok;
  assign sts.scan_ok   = in_range && scan_byte == CH_SEMI
                         && (k_r <= CNT_W'(SEMI_LIMIT)) && !big_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ----- hdl/html_entity_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// a plain byte is written into the window register, then moved to the output register when the sequencer emits it
// plain text: a new byte is accepted only after the previous one is emitted, set by the accept/emit controller loop
// a numeric entity is decoded by a scan start, then one scan step per digit, then an emit at the closing ';'
// a failed entity emits '&' then rescans the bytes behind it, one plain byte per cycle while the output is not stalled
// reset: synchronous active-low rst_n empties the window and the output register

module html_entity_decoder #(
  parameter int SEMI_LIMIT = hed_pkg::SEMI_LIMIT_DFLT
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hed_in_if.sink    in_chan,
  hed_out_if.source out_chan
);
  import hed_pkg::*;

  // command and status between the sequencer and the window datapath
  hed_cmd_t cmd;
  hed_sts_t sts;

  logic in_ready;
  logic out_valid;
  logic [7:0] out_byte;
  logic out_last;

  // sequencer: waits for a beat, then drains the window front one decision
  // at a time (pass-through byte, named entity, or numeric digit scan)
  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window buffer, entity matchers, digit accumulator and output register
  hed_dp #(
    .SEMI_LIMIT (SEMI_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_chan.in_byte),
    .in_last   (in_chan.in_last),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // input beats are taken only while the sequencer is idle; the output
  // register decouples a stalled sink from the next input beat
  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid;
  assign out_chan.out_byte = out_byte;
  assign out_chan.out_last = out_last;

`ifndef SYNTHESIS
  // never overwrite an output beat that has not been taken
  a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_chan.valid || out_chan.ready))
    else $error("emit into an occupied output register");

  // the window always has room for an accepted beat
  a_room : assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !sts.full)
    else $error("input ready with a full window");

  // one beat at a time: right after an accept the block is busy and not ready
  a_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input ready right after an accepted beat");

  // the last byte of a stream empties the window and is flagged last
  a_last : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.src == SRC_FRONT && sts.at_end && sts.single)
      |=> (out_chan.valid && out_chan.out_last && sts.cnt_zero))
    else $error("end of stream not flushed with a last beat");
`endif

endmodule

`default_nettype wire
